// ===== rtl/scfl_pkg.sv =====
package scfl_pkg;

  localparam int unsigned NCLASSES  = 385;
  localparam int unsigned CLS_W     = 9;
  localparam int unsigned MAX_TOTAL = 1048576;
  localparam int unsigned MODE_ALLOC   = 0;
  localparam int unsigned MODE_FREE    = 1;

  // Page count and page size are fixed by the 2-bit page and 21-bit offset fields.
  localparam int unsigned PAGES           = 4;
  localparam int unsigned PAGE_BYTES_LOG2 = 21;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_NO_PAGES = 2'd2,
    ST_DBL_FREE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'd0,
    S_IDLE  = 3'd1,
    S_RD1   = 3'd2,
    S_RD2   = 3'd3,
    S_WB    = 3'd4,
    S_OUT   = 3'd5
  } fsm_t;

  localparam logic [2:0] REG_CHUNK_HDR = 3'd0;
  localparam logic [2:0] REG_PAGE_HDR  = 3'd4;

  // Map a total byte count (at most 1 MiB) to its size class.
  function automatic logic [CLS_W-1:0] class_of(input logic [20:0] t);
    logic [4:0] l;
    logic [20:0] frac;
    logic [CLS_W-1:0] c;
    l = 5'd10;
    c = '0;
    if (t < 21'd1024) begin
      c = CLS_W'(t >> 4);
    end else if (t[20]) begin
      c = CLS_W'(384);
    end else begin
      for (int i = 11; i < 20; i++) begin
        if (t[i]) l = 5'(i);
      end
      frac = (t - (21'd1 << l)) >> (l - 5'd5);
      c = CLS_W'(64 + 32 * (int'(l) - 10)) + CLS_W'(frac[4:0]);
    end
    return c;
  endfunction

  // Byte size of a class.
  function automatic logic [20:0] class_bytes(input logic [CLS_W-1:0] c);
    logic [3:0] g;
    logic [5:0] k;
    logic [20:0] r;
    g = 4'((c - CLS_W'(64)) >> 5);
    k = 6'((c - CLS_W'(64)) & CLS_W'(31));
    if (c < CLS_W'(64)) r = 21'((c + 1) * 16);
    else if (c >= CLS_W'(384)) r = 21'(MAX_TOTAL);
    else r = (21'd1024 << g) + ((21'd32 << g) * 21'(k + 6'd1));
    return r;
  endfunction

endpackage

// ===== rtl/scfl_if.sv =====
interface scfl_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [20:0] request_bytes;
  logic [1:0]  chunk_page;
  logic [20:0] chunk_offset;
  modport source (output valid, mode, request_bytes, chunk_page, chunk_offset, input ready);
  modport sink (input valid, mode, request_bytes, chunk_page, chunk_offset, output ready);
endinterface

interface scfl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_page;
  logic [20:0] out_offset;
  logic [8:0]  size_class;
  logic [1:0]  status;
  modport source (output valid, out_page, out_offset, size_class, status, input ready);
  modport sink (input valid, out_page, out_offset, size_class, status, output ready);
endinterface

// ===== rtl/scfl_ram.sv =====
module scfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/size_class_free_list_allocator_top.sv =====
// A request is accepted in the idle state, then passes through the read states
// S_RD1 and S_RD2 and the write-back state S_WB; the result is then presented
// in S_OUT and is held until it is taken.
// A new request is not accepted until the result has been taken.
// Reset (synchronous, active low) restores the header registers and closes the
// page, then clears the class table with input ready held low.
module size_class_free_list_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  scfl_in_if.sink     in_ch,
  scfl_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import scfl_pkg::*;

  localparam int unsigned GRAN_W = PAGE_BYTES_LOG2 - 4;
  localparam int unsigned MA_W   = 2 + GRAN_W;
  localparam int unsigned CNT_W  = $clog2(PAGES + 1);
  localparam int unsigned FILL_W = PAGE_BYTES_LOG2 + 1;
  localparam int unsigned LEN_W  = 20;
  // list entry: length, head page(2), head granule(GRAN_W)
  localparam int unsigned LE_W   = LEN_W + 2 + GRAN_W;
  // meta: is_free, class, prev page(2), prev granule
  localparam int unsigned ME_W   = 1 + CLS_W + 2 + GRAN_W;

  logic [6:0] chdr_r;
  logic [8:0] phdr_r;
  fsm_t state_r, state_nxt;
  logic [CLS_W-1:0] clr_r;

  logic        mode_r;
  logic [20:0] req_r;
  logic [1:0]  rpg_r;
  logic [20:0] roff_r;
  logic [CLS_W-1:0] acls_r;
  logic        big_r;
  logic [20:0] csize_r;
  logic [CLS_W-1:0] cls_r;
  status_t     st_r;
  logic [1:0]  opg_r;
  logic [20:0] ooff_r;
  logic [CNT_W-1:0]  pused_r;
  logic [FILL_W-1:0] fill_r;
  logic              popen_r;

  // list ram
  logic             l_we;
  logic [CLS_W-1:0] l_wa, l_ra;
  logic [LE_W-1:0]  l_wd, l_rd;
  // meta ram
  logic             m_we;
  logic [MA_W-1:0]  m_ra, m_wa;
  logic [ME_W-1:0]  m_wd, m_rd;

  logic              in_fire;
  logic              is_rel;
  logic [21:0]       total;
  logic [CLS_W-1:0]  acls;
  logic [GRAN_W-1:0] rgran;
  logic              rel_bad;
  logic [CLS_W-1:0]  mcls_raw, mcls;
  logic              m_free;
  logic [1:0]        m_ppg;
  logic [GRAN_W-1:0] m_pgr;
  logic [LEN_W-1:0]  len;
  logic [1:0]        hpg;
  logic [GRAN_W-1:0] hgr;
  logic              need_page, no_page;
  logic [FILL_W-1:0] base_fill;
  logic [CNT_W-1:0]  new_pused;
  logic [1:0]        cpg;
  logic [GRAN_W-1:0] cgr;
  status_t           st_c;
  logic [1:0]        opg_c;
  logic [20:0]       ooff_c;
  logic [CLS_W-1:0]  cls_c;

  scfl_ram #(.WIDTH(LE_W), .DEPTH(NCLASSES)) u_list (
    .clk, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
  scfl_ram #(.WIDTH(ME_W), .DEPTH(PAGES << GRAN_W)) u_meta (
    .clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));

  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr)
      REG_CHUNK_HDR: cfg_prdata = {25'd0, chdr_r};
      REG_PAGE_HDR:  cfg_prdata = {23'd0, phdr_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign is_rel = (mode_r == MODE_FREE[0]);

  // Allocate path, computed from the captured request.
  assign total = {1'b0, req_r} + 22'(chdr_r);
  assign acls  = class_of(total[20:0]);

  assign rgran = roff_r[GRAN_W+3:4];
  assign rel_bad = (32'(rpg_r) >= PAGES);

  assign mcls_raw = m_rd[ME_W-2 -: CLS_W];
  assign mcls = (mcls_raw >= CLS_W'(NCLASSES)) ? CLS_W'(NCLASSES - 1) : mcls_raw;
  assign m_free = m_rd[ME_W-1];
  assign m_ppg  = m_rd[GRAN_W+1 -: 2];
  assign m_pgr  = m_rd[GRAN_W-1:0];
  assign len = l_rd[LE_W-1 -: LEN_W];
  assign hpg = l_rd[GRAN_W+1 -: 2];
  assign hgr = l_rd[GRAN_W-1:0];

  assign need_page = !popen_r ||
      ((FILL_W'(1) << PAGE_BYTES_LOG2) - fill_r < FILL_W'(csize_r));
  assign no_page = need_page && (32'(pused_r) >= PAGES);
  assign base_fill = need_page ? FILL_W'(phdr_r) : fill_r;
  assign new_pused = need_page ? pused_r + CNT_W'(1) : pused_r;
  assign cpg = 2'(new_pused - CNT_W'(1));
  assign cgr = base_fill[GRAN_W+3:4];

  // Allocate reads the class entry, then the head chunk's metadata; release
  // reads the chunk's metadata, then the entry of its class.
  assign l_ra = is_rel ? mcls : acls;
  assign m_ra = is_rel ? {rpg_r, rgran} : {hpg, hgr};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == CLS_W'(NCLASSES - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_RD1;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_WB;
      S_WB:    state_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    l_we = 1'b0; l_wa = acls_r; l_wd = '0;
    m_we = 1'b0; m_wa = {hpg, hgr}; m_wd = '0;
    st_c = ST_OK; opg_c = '0; ooff_c = '0; cls_c = '0;
    if (is_rel) begin
      opg_c = rpg_r; ooff_c = roff_r;
      if (rel_bad) begin
        st_c = ST_DBL_FREE;
      end else if (m_free) begin
        st_c = ST_DBL_FREE; cls_c = mcls;
      end else begin
        cls_c = mcls;
        m_we = (state_r == S_WB); m_wa = {rpg_r, rgran};
        m_wd = {1'b1, mcls_raw, hpg, hgr};
        l_we = (state_r == S_WB); l_wa = mcls;
        l_wd = {len + 20'd1, rpg_r, rgran};
      end
    end else if (big_r) begin
      st_c = ST_TOO_BIG;
    end else begin
      cls_c = acls_r;
      if (len != '0) begin
        opg_c = hpg; ooff_c = {hgr, 4'd0};
        l_we = (state_r == S_WB); l_wd = {len - 20'd1, m_ppg, m_pgr};
        m_we = (state_r == S_WB);
        m_wd = {1'b0, mcls_raw, 2'd0, {GRAN_W{1'b0}}};
      end else if (no_page) begin
        st_c = ST_NO_PAGES;
      end else begin
        opg_c = cpg; ooff_c = {cgr, 4'd0};
        m_we = (state_r == S_WB); m_wa = {cpg, cgr};
        m_wd = {1'b0, acls_r, 2'd0, {GRAN_W{1'b0}}};
      end
    end
    // After reset every class entry is zeroed, which empties all lists.
    if (state_r == S_CLEAR) begin
      l_we = 1'b1; l_wa = clr_r; l_wd = '0;
      m_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      chdr_r  <= 7'd32;
      phdr_r  <= 9'd16;
      pused_r <= '0;
      fill_r  <= '0;
      popen_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + CLS_W'(1);
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr == REG_CHUNK_HDR) chdr_r <= cfg_pwdata[6:0] & 7'h70;
        if (cfg_paddr == REG_PAGE_HDR)  phdr_r <= cfg_pwdata[8:0] & 9'h1F0;
      end
      if (state_r == S_WB && !is_rel && !big_r && len == '0 && !no_page) begin
        pused_r <= new_pused;
        popen_r <= 1'b1;
        fill_r  <= base_fill + FILL_W'(csize_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_ch.mode;
      req_r  <= in_ch.request_bytes;
      rpg_r  <= in_ch.chunk_page;
      roff_r <= in_ch.chunk_offset;
    end
    if (state_r == S_RD1) begin
      acls_r <= acls;
      big_r  <= (total > 22'(MAX_TOTAL));
    end
    if (state_r == S_RD2) csize_r <= class_bytes(acls_r);
    if (state_r == S_WB) begin
      st_r <= st_c; opg_r <= opg_c; ooff_r <= ooff_c; cls_r <= cls_c;
    end
  end

  assign out_ch.valid      = (state_r == S_OUT);
  assign out_ch.out_page   = opg_r;
  assign out_ch.out_offset = ooff_r;
  assign out_ch.size_class = cls_r;
  assign out_ch.status     = st_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid &&
      $stable({out_ch.out_page, out_ch.out_offset, out_ch.size_class, out_ch.status})))
    else $error("result changed while waiting");
  a_pages: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pused_r) <= PAGES) else $error("page count overflow");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    popen_r |-> (fill_r <= (FILL_W'(1) << PAGE_BYTES_LOG2))) else $error("page overfilled");
`endif
endmodule
